FILE: rtl/pfs_pkg.sv
`default_nettype none

package pfs_pkg;

	localparam logic       OP_CLEAR       = 1'b0;
	localparam logic       OP_PACKET      = 1'b1;

	localparam logic [1:0] DIR_UP         = 2'd0;
	localparam logic [1:0] DIR_DOWN       = 2'd1;

	localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  PROTO_TCP       = 8'd6;
	localparam logic [7:0]  IHL_MASK        = 8'h0F;
	localparam logic [15:0] ETHER_HDR_BYTES = 16'd14;
	localparam logic [15:0] TCP_HDR_BYTES   = 16'd20;
	localparam logic [15:0] MEAN_MAX        = 16'hFFFF;
	localparam logic [15:0] MIN_LEN_RESET   = 16'hFFFF;

	typedef struct packed {
		logic        opcode;
		logic [63:0] timestamp;
		logic [1:0]  direction;
		logic [15:0] packet_length;
		logic [15:0] segment_length;
		logic [15:0] frame_type;
		logic [7:0]  ip_protocol;
		logic [7:0]  ip_ver_len;
		logic [7:0]  tcp_flag_bits;
		logic [15:0] tcp_window;
	} in_t;

	typedef struct packed {
		logic [63:0] total_packets;
		logic [63:0] total_bytes;
		logic [63:0] up_packet_count;
		logic [63:0] up_byte_count;
		logic [63:0] down_packet_count;
		logic [63:0] down_byte_count;
		logic [15:0] smallest_length;
		logic [15:0] largest_length;
		logic [15:0] mean_length;
		logic [7:0]  flags_seen;
		logic [15:0] largest_window;
		logic [63:0] elapsed_cycles;
	} out_t;

endpackage

`default_nettype wire

FILE: rtl/pfs_divider.sv
`default_nettype none

module pfs_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [63:0] divisor,
	output logic             done,
	output logic [15:0]      quotient
);
	import pfs_pkg::*;

	logic        running_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] div_q;
	logic [64:0] shifted;
	logic [64:0] diff;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[63]};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			cnt_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= !start && running_q && (cnt_q == 6'd63);
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					running_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (running_q) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[63:16]) ? MEAN_MAX : quo_q[15:0];

endmodule

`default_nettype wire

FILE: rtl/packet_flow_statistics_unit.sv
`default_nettype none

// Statistics for one flow. Each item is a clear (zeroes the counters and
// stamps first-seen and last-seen) or one packet to account; every item gives
// one result, a snapshot of all statistics after the item. The block takes
// one item at a time. A clear goes from the accept straight to handing the
// result over; a packet passes through the accept, five steps of one shared
// 64-bit adder over the four counter updates and the elapsed time, a divider
// start, a bit-serial divider that forms the mean length, the capture of the
// quotient and the hand-over of the result. A finished result is held in an
// output register, so the next item may be accepted while the result still
// waits to be taken; a stall on the result side only adds cycles when a
// result is still waiting as the next one finishes.
module packet_flow_statistics_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire pfs_pkg::in_t  item,
	output logic               result_valid,
	input  wire logic          result_stall,
	output pfs_pkg::out_t      result
);
	import pfs_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ADD   = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_WAIT  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [2:0] STEP_PKT     = 3'd0;
	localparam logic [2:0] STEP_BYTES   = 3'd1;
	localparam logic [2:0] STEP_DIR_PKT = 3'd2;
	localparam logic [2:0] STEP_DIR_BYT = 3'd3;
	localparam logic [2:0] STEP_ELAPSED = 3'd4;

	logic [2:0]  state_q;
	logic [2:0]  step_q;
	logic        result_valid_q;
	out_t        result_q;

	logic [63:0] packets_q;
	logic [63:0] bytes_q;
	logic [63:0] up_packets_q;
	logic [63:0] up_bytes_q;
	logic [63:0] down_packets_q;
	logic [63:0] down_bytes_q;
	logic [15:0] min_len_q;
	logic [15:0] max_len_q;
	logic [7:0]  flags_q;
	logic [15:0] window_q;
	logic [63:0] first_seen_q;
	logic [63:0] last_seen_q;
	logic [63:0] elapsed_q;
	logic [15:0] mean_q;
	logic [1:0]  dir_q;
	logic [15:0] plen_q;

	logic        accept;
	logic        result_free;
	logic        tcp_ok;
	logic [15:0] need_bytes;
	logic [63:0] add_a;
	logic [63:0] add_b;
	logic        add_cin;
	logic [63:0] add_sum;
	logic        div_start;
	logic        div_done;
	logic [15:0] div_quotient;

	assign accept       = item_valid && !item_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_free  = !result_valid_q || !result_stall;

	assign need_bytes = ETHER_HDR_BYTES + {6'd0, (item.ip_ver_len & IHL_MASK), 2'b00}
		+ TCP_HDR_BYTES;
	assign tcp_ok = (item.frame_type == ETHERTYPE_IPV4) && (item.ip_protocol == PROTO_TCP)
		&& (item.segment_length >= need_bytes);

	// shared adder operand select
	always_comb begin
		add_a   = packets_q;
		add_b   = 64'd1;
		add_cin = 1'b0;
		case (step_q)
			STEP_PKT: begin
				add_a = packets_q;
				add_b = 64'd1;
			end
			STEP_BYTES: begin
				add_a = bytes_q;
				add_b = {48'd0, plen_q};
			end
			STEP_DIR_PKT: begin
				add_a = (dir_q == DIR_UP) ? up_packets_q : down_packets_q;
				add_b = 64'd1;
			end
			STEP_DIR_BYT: begin
				add_a = (dir_q == DIR_UP) ? up_bytes_q : down_bytes_q;
				add_b = {48'd0, plen_q};
			end
			STEP_ELAPSED: begin
				add_a   = last_seen_q;
				add_b   = ~first_seen_q;
				add_cin = 1'b1;
			end
			default: begin
				add_a = packets_q;
				add_b = 64'd1;
			end
		endcase
	end

	assign add_sum = add_a + add_b + {63'd0, add_cin};

	assign div_start = (state_q == ST_DIV);

	pfs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (bytes_q),
		.divisor  (packets_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && result_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= STEP_PKT;
			packets_q      <= '0;
			bytes_q        <= '0;
			up_packets_q   <= '0;
			up_bytes_q     <= '0;
			down_packets_q <= '0;
			down_bytes_q   <= '0;
			min_len_q      <= MIN_LEN_RESET;
			max_len_q      <= '0;
			flags_q        <= '0;
			window_q       <= '0;
			first_seen_q   <= '0;
			last_seen_q    <= '0;
			elapsed_q      <= '0;
			mean_q         <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_seen_q <= item.timestamp;
						if (item.opcode == OP_CLEAR) begin
							packets_q      <= '0;
							bytes_q        <= '0;
							up_packets_q   <= '0;
							up_bytes_q     <= '0;
							down_packets_q <= '0;
							down_bytes_q   <= '0;
							min_len_q      <= MIN_LEN_RESET;
							max_len_q      <= '0;
							flags_q        <= '0;
							window_q       <= '0;
							first_seen_q   <= item.timestamp;
							elapsed_q      <= '0;
							mean_q         <= '0;
							state_q        <= ST_DONE;
						end else begin
							if (item.packet_length < min_len_q) begin
								min_len_q <= item.packet_length;
							end
							if (item.packet_length > max_len_q) begin
								max_len_q <= item.packet_length;
							end
							if (tcp_ok) begin
								flags_q <= flags_q | item.tcp_flag_bits;
								if (item.tcp_window > window_q) begin
									window_q <= item.tcp_window;
								end
							end
							step_q  <= STEP_PKT;
							state_q <= ST_ADD;
						end
					end
				end
				ST_ADD: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						STEP_PKT: begin
							packets_q <= add_sum;
						end
						STEP_BYTES: begin
							bytes_q <= add_sum;
						end
						STEP_DIR_PKT: begin
							if (dir_q == DIR_UP) begin
								up_packets_q <= add_sum;
							end else if (dir_q == DIR_DOWN) begin
								down_packets_q <= add_sum;
							end
						end
						STEP_DIR_BYT: begin
							if (dir_q == DIR_UP) begin
								up_bytes_q <= add_sum;
							end else if (dir_q == DIR_DOWN) begin
								down_bytes_q <= add_sum;
							end
						end
						STEP_ELAPSED: begin
							elapsed_q <= add_sum;
							if (packets_q == 64'd0) begin
								mean_q  <= '0;
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_DIV;
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DIV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						mean_q  <= div_quotient;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (result_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dir_q  <= item.direction;
			plen_q <= item.packet_length;
		end
		if ((state_q == ST_DONE) && result_free) begin
			result_q.total_packets     <= packets_q;
			result_q.total_bytes       <= bytes_q;
			result_q.up_packet_count   <= up_packets_q;
			result_q.up_byte_count     <= up_bytes_q;
			result_q.down_packet_count <= down_packets_q;
			result_q.down_byte_count   <= down_bytes_q;
			result_q.smallest_length   <= (packets_q == 64'd0) ? 16'd0 : min_len_q;
			result_q.largest_length    <= max_len_q;
			result_q.mean_length       <= mean_q;
			result_q.flags_seen        <= flags_q;
			result_q.largest_window    <= window_q;
			result_q.elapsed_cycles    <= elapsed_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

FILE: bench/tb_packet_flow_statistics_unit.sv
`timescale 1ns / 100ps

module tb_packet_flow_statistics_unit;
	import pfs_pkg::*;

	localparam logic [1:0] DIR_NONE = 2'd2;
	localparam logic [1:0] DIR_ODD  = 2'd3;
	localparam int RANDOM_ITEMS = 1250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_t  item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result;

	in_t  items_to_send[$];
	out_t snapshots_due[$];
	int   send_gap = 0;
	int   stall_left = 0;
	int   items_accepted = 0;
	int   results_checked = 0;
	int   clears_seen = 0;
	int   tcp_updates = 0;
	int   error_count = 0;

	// flow statistics as the block should hold them
	logic [63:0] pkt_total, byte_total, up_pkts, up_octets, down_pkts, down_octets;
	logic [15:0] min_len = MIN_LEN_RESET;
	logic [15:0] max_len, win_max;
	logic [7:0]  flags_acc;
	logic [63:0] first_ts, last_ts;

	initial begin
		{pkt_total, byte_total, up_pkts, up_octets, down_pkts, down_octets} = '0;
		{max_len, win_max, flags_acc, first_ts, last_ts} = '0;
	end

	// quiet stretches with no idling on either side
	wire calm = ((items_accepted / 100) % 4) == 3;

	packet_flow_statistics_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 150);
	endfunction

	function automatic in_t make_item(logic op, logic [63:0] ts, logic [1:0] dir,
			logic [15:0] plen, logic [15:0] seg, logic [15:0] etype, logic [7:0] proto,
			logic [7:0] vihl, logic [7:0] tflags, logic [15:0] twin);
		in_t it;
		it.opcode = op;
		it.timestamp = ts;
		it.direction = dir;
		it.packet_length = plen;
		it.segment_length = seg;
		it.frame_type = etype;
		it.ip_protocol = proto;
		it.ip_ver_len = vihl;
		it.tcp_flag_bits = tflags;
		it.tcp_window = twin;
		return it;
	endfunction

	task automatic apply_item(input in_t it, output out_t snap);
		logic [15:0] hdr_need;
		logic [63:0] quot;
		if (it.opcode == OP_CLEAR) begin
			{pkt_total, byte_total, up_pkts, up_octets, down_pkts, down_octets} = '0;
			min_len = MIN_LEN_RESET;
			{max_len, flags_acc, win_max} = '0;
			first_ts = it.timestamp;
			last_ts = it.timestamp;
			clears_seen++;
		end else begin
			pkt_total += 64'd1;
			byte_total += 64'(it.packet_length);
			last_ts = it.timestamp;
			if (it.direction == DIR_UP) begin
				up_pkts += 64'd1;
				up_octets += 64'(it.packet_length);
			end else if (it.direction == DIR_DOWN) begin
				down_pkts += 64'd1;
				down_octets += 64'(it.packet_length);
			end
			if (it.packet_length < min_len) min_len = it.packet_length;
			if (it.packet_length > max_len) max_len = it.packet_length;
			if (it.frame_type == ETHERTYPE_IPV4 && it.ip_protocol == PROTO_TCP) begin
				hdr_need = ETHER_HDR_BYTES + TCP_HDR_BYTES
					+ {6'd0, (it.ip_ver_len & IHL_MASK), 2'b00};
				if (it.segment_length >= hdr_need) begin
					flags_acc |= it.tcp_flag_bits;
					if (it.tcp_window > win_max) win_max = it.tcp_window;
					tcp_updates++;
				end
			end
		end
		snap.total_packets = pkt_total;
		snap.total_bytes = byte_total;
		snap.up_packet_count = up_pkts;
		snap.up_byte_count = up_octets;
		snap.down_packet_count = down_pkts;
		snap.down_byte_count = down_octets;
		snap.smallest_length = (pkt_total == 0) ? 16'd0 : min_len;
		snap.largest_length = max_len;
		if (pkt_total == 0) begin
			snap.mean_length = 16'd0;
		end else begin
			quot = byte_total / pkt_total;
			snap.mean_length = (quot > 64'(MEAN_MAX)) ? MEAN_MAX : quot[15:0];
		end
		snap.flags_seen = flags_acc;
		snap.largest_window = win_max;
		snap.elapsed_cycles = last_ts - first_ts;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// driver
	always @(posedge clk) begin
		out_t snap;
		int n;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				apply_item(item, snap);
				snapshots_due.push_back(snap);
				items_accepted++;
				n = calm ? 0 : idle_length();
				if (n == 0 && items_to_send.size() > 0) begin
					item <= items_to_send.pop_front();
				end else begin
					item_valid <= 1'b0;
					send_gap <= n;
				end
			end else if (!item_valid) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (items_to_send.size() > 0) begin
					item <= items_to_send.pop_front();
					item_valid <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_t want;
		int n;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (snapshots_due.size() == 0) begin
					$error("result with no item outstanding");
					error_count++;
				end else begin
					want = snapshots_due.pop_front();
					results_checked++;
					check_field("total_packets", want.total_packets, result.total_packets);
					check_field("total_bytes", want.total_bytes, result.total_bytes);
					check_field("up_packet_count", want.up_packet_count,
						result.up_packet_count);
					check_field("up_byte_count", want.up_byte_count, result.up_byte_count);
					check_field("down_packet_count", want.down_packet_count,
						result.down_packet_count);
					check_field("down_byte_count", want.down_byte_count,
						result.down_byte_count);
					check_field("smallest_length", 64'(want.smallest_length),
						64'(result.smallest_length));
					check_field("largest_length", 64'(want.largest_length),
						64'(result.largest_length));
					check_field("mean_length", 64'(want.mean_length),
						64'(result.mean_length));
					check_field("flags_seen", 64'(want.flags_seen),
						64'(result.flags_seen));
					check_field("largest_window", 64'(want.largest_window),
						64'(result.largest_window));
					check_field("elapsed_cycles", want.elapsed_cycles,
						result.elapsed_cycles);
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1'b1;
			end else begin
				n = calm ? 0 : idle_length();
				result_stall <= (n > 0);
				if (n > 0) stall_left <= n - 1;
			end
		end
	end

	initial begin
		logic [63:0] ts_now;
		logic [15:0] need, plen, seg, etype;
		logic [7:0]  proto, vihl, tflags;
		logic [1:0]  dir;
		int r;

		// packet straight after reset, then the edge cases
		items_to_send.push_back(make_item(OP_PACKET, 64'd100, DIR_UP, 16'd60, 16'd60,
			16'h0800, 8'd6, 8'h45, 8'h02, 16'd1000));
		items_to_send.push_back(make_item(OP_CLEAR, 64'd0, DIR_UP, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
		items_to_send.push_back(make_item(OP_PACKET, 64'd1, DIR_UP, 16'd0, 16'd0,
			16'd0, 8'd0, 8'd0, 8'd0, 16'd0));
		items_to_send.push_back(make_item(OP_PACKET, 64'd2, DIR_DOWN, 16'hFFFF, 16'd54,
			ETHERTYPE_IPV4, PROTO_TCP, 8'h45, 8'hFF, 16'hFFFF));
		items_to_send.push_back(make_item(OP_PACKET, 64'd3, DIR_NONE, 16'd1500, 16'd53,
			ETHERTYPE_IPV4, PROTO_TCP, 8'h45, 8'h10, 16'd5));
		items_to_send.push_back(make_item(OP_PACKET, 64'd4, DIR_ODD, 16'd40, 16'd40,
			16'h86DD, PROTO_TCP, 8'h45, 8'h01, 16'd7));
		items_to_send.push_back(make_item(OP_CLEAR, '1, DIR_ODD, 16'd0, 16'd0,
			16'd0, 8'd0, 8'd0, 8'd0, 16'd0));
		items_to_send.push_back(make_item(OP_PACKET, 64'd5, DIR_UP, 16'hFFFF, 16'd93,
			ETHERTYPE_IPV4, PROTO_TCP, 8'hAF, 8'h01, 16'd1));
		items_to_send.push_back(make_item(OP_PACKET, 64'd6, DIR_DOWN, 16'hFFFF, 16'd94,
			ETHERTYPE_IPV4, PROTO_TCP, 8'h0F, 8'h04, 16'd2));
		items_to_send.push_back(make_item(OP_PACKET, 64'd7, DIR_UP, 16'd100, 16'd34,
			ETHERTYPE_IPV4, PROTO_TCP, 8'h40, 8'h08, 16'd3));
		items_to_send.push_back(make_item(OP_PACKET, 64'd8, DIR_UP, 16'd200, 16'd33,
			ETHERTYPE_IPV4, PROTO_TCP, 8'hF0, 8'h80, 16'hFFFF));
		items_to_send.push_back(make_item(OP_PACKET, 64'd9, DIR_DOWN, 16'd300, 16'hFFFF,
			ETHERTYPE_IPV4, 8'd17, 8'h45, 8'h40, 16'hFFFF));
		items_to_send.push_back(make_item(OP_PACKET, 64'd10, DIR_NONE, 16'd1, 16'hFFFF,
			ETHERTYPE_IPV4, PROTO_TCP, 8'hFF, 8'h20, 16'h8000));
		items_to_send.push_back(make_item(OP_PACKET, '1, DIR_ODD, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF));
		items_to_send.push_back(make_item(OP_CLEAR, 64'h8000_0000_0000_0000, DIR_DOWN,
			16'h5555, 16'hAAAA, 16'h0800, 8'd6, 8'h45, 8'h00, 16'h0000));

		ts_now = {$urandom, $urandom};
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			ts_now += 64'($urandom_range(1, 5000));
			if ($urandom_range(0, 99) < 6) begin
				if ($urandom_range(0, 3) == 0) ts_now = {$urandom, $urandom};
				items_to_send.push_back(make_item(OP_CLEAR, ts_now, 2'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 16'($urandom)));
				continue;
			end
			r = $urandom_range(0, 9);
			dir = (r < 4) ? DIR_UP : (r < 8) ? DIR_DOWN : (r == 8) ? DIR_NONE : DIR_ODD;
			plen = ($urandom_range(0, 4) == 0) ? 16'($urandom)
				: 16'($urandom_range(60, 1514));
			r = $urandom_range(0, 9);
			etype = (r < 8) ? ETHERTYPE_IPV4 : (r == 8) ? 16'($urandom) : ETHERTYPE_IPV4;
			proto = (r < 8) ? PROTO_TCP : (r == 8) ? PROTO_TCP : 8'($urandom);
			vihl = ($urandom_range(0, 9) < 7) ? 8'h45 : 8'($urandom);
			need = ETHER_HDR_BYTES + TCP_HDR_BYTES + {10'd0, vihl[3:0], 2'b00};
			r = $urandom_range(0, 9);
			if (r < 4) seg = need + 16'($urandom_range(0, 1500));
			else if (r < 6) seg = need + 16'($urandom_range(0, 2)) - 16'd1;
			else seg = 16'($urandom);
			tflags = ($urandom_range(0, 4) == 0) ? 8'($urandom)
				: 8'(1 << $urandom_range(0, 7));
			items_to_send.push_back(make_item(OP_PACKET, ts_now, dir, plen, seg, etype,
				proto, vihl, tflags, 16'($urandom)));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (items_to_send.size() > 0 || item_valid) @(posedge clk);
		while (snapshots_due.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("%0d items accepted: %0d clears, %0d packets, %0d with tcp header updates",
			items_accepted, clears_seen, items_accepted - clears_seen, tcp_updates);
		$display("%0d result snapshots compared field by field", results_checked);
		if (error_count == 0) begin
			$display("tb_packet_flow_statistics_unit: clean");
		end else begin
			$display("tb_packet_flow_statistics_unit: errors");
		end
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("tb_packet_flow_statistics_unit: errors");
		$finish;
	end

endmodule
